// ===== sv/mmp_pkg.sv =====
// Shared types and constants for the modular 2x2 matrix power block.
// Holds the item layouts, the lane operand struct, the sequencer states
// and the modulus constants. Depends on nothing.
package mmp_pkg;

  localparam int ELEM_W    = 30;
  localparam int EXP_W     = 63;
  localparam int NUM_LANES = 8;
  localparam int LANE_LAT  = 6;

  typedef logic [ELEM_W-1:0] elem_t;

  // Modulus and the constants derived from it for Barrett reduction.
  localparam elem_t       MOD_P     = 30'd1000000007;
  localparam logic [31:0] MOD_P_W   = 32'(MOD_P);
  localparam logic [31:0] MOD_2P_W  = 32'(MOD_P) << 1;
  localparam logic [63:0] BARRETT_M64 = (64'd1 << 61) / 64'(MOD_P);
  localparam logic [31:0] BARRETT_M = BARRETT_M64[31:0];

  localparam elem_t ELEM_ZERO = '0;
  localparam elem_t ELEM_ONE  = 30'd1;

  // Row-major 2x2 matrix of residues, indexed [row][column].
  typedef elem_t [1:0][1:0] mat_t;

  typedef struct packed {
    elem_t             entry_00;
    elem_t             entry_01;
    elem_t             entry_10;
    elem_t             entry_11;
    logic [EXP_W-1:0]  exponent;
  } in_item_t;

  typedef struct packed {
    elem_t power_00;
    elem_t power_01;
    elem_t power_10;
    elem_t power_11;
  } out_item_t;

  // Operands of one modular dot product a*b + c*d.
  typedef struct packed {
    elem_t a;
    elem_t b;
    elem_t c;
    elem_t d;
  } lane_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } ctrl_state_t;

  // Brings a raw 30-bit entry into 0..MOD_P-1; the input is below 2*MOD_P.
  function automatic elem_t reduce_entry(input elem_t x);
    elem_t r;
    r = (x >= MOD_P) ? x - MOD_P : x;
    return r;
  endfunction

endpackage

// ===== sv/mmp_stream_if.sv =====
// Valid/ready channel used for the input and result items.
// The payload type is a parameter; no other dependencies.
interface mmp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/modular_matrix_power_2x2.sv =====
// Top level of the modular 2x2 matrix power block: eight dot-product lanes,
// the sequencer and the result register. Depends on mmp_pkg,
// mmp_stream_if, mmp_lane and mmp_ctrl.
//
//   Channel  Role    Payload      Accepted when
//   req      sink    in_item_t    req.valid && req.ready
//   rsp      source  out_item_t   rsp.valid && rsp.ready
//
// An item runs one round per exponent bit, up to and including the highest set
// bit among the low EXP_BITS exponent bits, and no round for a zero exponent.
// Each round is one issue step and a pass through the six-stage lane pipeline,
// whose output feeds the next bit's operands.
// Reset is synchronous and clears the sequencer, lane valid bits and the
// result valid. A new item is accepted while a result waits in the output
// register; a stalled result holds only the sequencer at its final step.
module modular_matrix_power_2x2
  import mmp_pkg::*;
#(
  parameter int EXP_BITS = 63
) (
  input  logic         clk,
  input  logic         rst,
  mmp_stream_if.sink   req,
  mmp_stream_if.source rsp
);

  logic                      issue;
  lane_op_t [NUM_LANES-1:0]  ops;
  logic [NUM_LANES-1:0]      lane_done;
  elem_t [NUM_LANES-1:0]     res;
  logic                      done_valid;
  out_item_t                 done_data;
  logic                      out_free;
  logic                      out_vld;
  out_item_t                 out_data;

  mmp_ctrl #(
    .EXP_BITS (EXP_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .issue      (issue),
    .ops        (ops),
    .lanes_done (&lane_done),
    .res        (res),
    .done_valid (done_valid),
    .done_data  (done_data),
    .out_take   (out_free)
  );

  // Dot-product lanes, all issued together.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mmp_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .issue (issue),
      .op    (ops[g]),
      .done  (lane_done[g]),
      .res   (res[g])
    );
  end

  // Result register parts the sequencer from the output handshake.
  assign out_free = !out_vld || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (done_valid && out_free) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && out_free) begin
      out_data <= done_data;
    end
  end

  assign rsp.valid = out_vld;
  assign rsp.data  = out_data;

endmodule

// ===== sv/mmp_lane.sv =====
// One lane: a pipelined modular dot product (a*b + c*d) mod MOD_P.
// Uses Barrett reduction over six register stages. Depends on mmp_pkg.
module mmp_lane
  import mmp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     issue,
  input  lane_op_t op,
  output logic     done,
  output elem_t    res
);

  logic [LANE_LAT-1:0] vld;
  logic [59:0]         prod_ab;
  logic [59:0]         prod_cd;
  logic [60:0]         sum;
  logic [63:0]         qest;
  logic [31:0]         sum_lo3;
  logic [31:0]         qp;
  logic [31:0]         sum_lo4;
  logic [31:0]         rem;

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LANE_LAT-2:0], issue};
    end
  end

  // Stage 1: the two products. Stage 2: their sum, below 2^61.
  always_ff @(posedge clk) begin
    prod_ab <= 60'(op.a) * 60'(op.b);
    prod_cd <= 60'(op.c) * 60'(op.d);
    sum     <= {1'b0, prod_ab} + {1'b0, prod_cd};
  end

  // Stage 3: quotient estimate from the top bits of the sum. The estimate
  // never exceeds the true quotient and falls short by at most two.
  always_ff @(posedge clk) begin
    qest    <= 64'(sum[60:29]) * 64'(BARRETT_M);
    sum_lo3 <= sum[31:0];
  end

  // Stage 4: quotient times modulus; the remainder is below 3*MOD_P, so
  // only the low 32 bits matter.
  always_ff @(posedge clk) begin
    qp      <= 32'(qest[63:32] * MOD_P_W);
    sum_lo4 <= sum_lo3;
  end

  // Stage 5: partial remainder. Stage 6: final correction.
  always_ff @(posedge clk) begin
    rem <= sum_lo4 - qp;
    if (rem >= MOD_2P_W) begin
      res <= 30'(rem - MOD_2P_W);
    end else if (rem >= MOD_P_W) begin
      res <= 30'(rem - MOD_P_W);
    end else begin
      res <= rem[ELEM_W-1:0];
    end
  end

  assign done = vld[LANE_LAT-1];

endmodule

// ===== sv/mmp_ctrl.sv =====
// Sequencer for the matrix power: holds the running square, the
// accumulator and the remaining exponent, feeds the lanes and merges their
// results back into the two matrices. Depends on mmp_pkg and mmp_stream_if.
module mmp_ctrl
  import mmp_pkg::*;
#(
  parameter int EXP_BITS = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  mmp_stream_if.sink                  req,
  output logic                        issue,
  output lane_op_t [NUM_LANES-1:0]    ops,
  input  logic                        lanes_done,
  input  elem_t [NUM_LANES-1:0]       res,
  output logic                        done_valid,
  output out_item_t                   done_data,
  input  logic                        out_take
);

  ctrl_state_t         state;
  ctrl_state_t         state_next;
  mat_t                sq;
  mat_t                acc;
  logic [EXP_BITS-1:0] e;
  logic [EXP_BITS-1:0] e_load;

  assign e_load = req.data.exponent[EXP_BITS-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (e_load == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (lanes_done) begin
          state_next = ((e >> 1) == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (out_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    req.ready  = (state == ST_IDLE);
    issue      = (state == ST_ISSUE);
    done_valid = (state == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Lane operands: lanes 0..3 square the running square, lanes 4..7
  // multiply the accumulator by it. Lane 2*i+j forms entry [i][j].
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        ops[2*i+j]   = '{a: sq[i][0], b: sq[0][j], c: sq[i][1], d: sq[1][j]};
        ops[4+2*i+j] = '{a: acc[i][0], b: sq[0][j], c: acc[i][1], d: sq[1][j]};
      end
    end
  end

  // Matrix and exponent registers: load on accept, merge lane results
  // once per exponent bit.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      sq[0][0]  <= reduce_entry(req.data.entry_00);
      sq[0][1]  <= reduce_entry(req.data.entry_01);
      sq[1][0]  <= reduce_entry(req.data.entry_10);
      sq[1][1]  <= reduce_entry(req.data.entry_11);
      acc[0][0] <= ELEM_ONE;
      acc[0][1] <= ELEM_ZERO;
      acc[1][0] <= ELEM_ZERO;
      acc[1][1] <= ELEM_ONE;
      e         <= e_load;
    end else if (state == ST_WAIT && lanes_done) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          sq[i][j] <= res[2*i+j];
          if (e[0]) begin
            acc[i][j] <= res[4+2*i+j];
          end
        end
      end
      e <= e >> 1;
    end
  end

  assign done_data = '{power_00: acc[0][0], power_01: acc[0][1],
                       power_10: acc[1][0], power_11: acc[1][1]};

endmodule

// ===== test/modular_matrix_power_2x2_tb.sv =====
`timescale 1ns / 1ps
// Testbench for modular_matrix_power_2x2: corner-case and random 2x2 matrices and
// exponents, each result checked against an internal modular square-and-multiply.
// Depends on mmp_pkg, mmp_stream_if and the block's RTL.
module modular_matrix_power_2x2_tb;
  import mmp_pkg::*;

  localparam int EXP_BITS     = 63;
  localparam int DRAIN_CYCLES = 450;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RANDOM_ITEMS = 800;
  localparam int MAX_REPORTS  = 10;

  // Matrix entries held at 64 bits so that products and sums need no care.
  typedef logic [1:0][1:0][63:0] wide_mat_t;

  // Computes the expected power for each accepted item and checks results in order.
  class power_scoreboard;
    out_item_t   expected_powers[$];
    int unsigned error_count;

    function wide_mat_t mat_product(wide_mat_t x, wide_mat_t y);
      wide_mat_t r;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          r[i][j] = (x[i][0] * y[0][j] + x[i][1] * y[1][j]) % 64'(MOD_P);
      return r;
    endfunction

    // Square-and-multiply from the lowest exponent bit, starting at the identity.
    function out_item_t matrix_power(in_item_t item);
      wide_mat_t base;
      wide_mat_t acc;
      out_item_t res;
      base[0][0] = 64'(item.entry_00) % 64'(MOD_P);
      base[0][1] = 64'(item.entry_01) % 64'(MOD_P);
      base[1][0] = 64'(item.entry_10) % 64'(MOD_P);
      base[1][1] = 64'(item.entry_11) % 64'(MOD_P);
      acc = '0;
      acc[0][0] = 64'd1;
      acc[1][1] = 64'd1;
      for (int i = 0; i < EXP_BITS; i++) begin
        if (item.exponent[i]) begin
          acc = mat_product(acc, base);
        end
        base = mat_product(base, base);
      end
      res.power_00 = elem_t'(acc[0][0]);
      res.power_01 = elem_t'(acc[0][1]);
      res.power_10 = elem_t'(acc[1][0]);
      res.power_11 = elem_t'(acc[1][1]);
      return res;
    endfunction

    // Appends the expected power of an accepted item to the tail of the queue.
    function void note_request(in_item_t item);
      expected_powers = {expected_powers, matrix_power(item)};
    endfunction

    function void check_power(out_item_t got);
      out_item_t want;
      if (expected_powers.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected result: %0d %0d %0d %0d",
                   got.power_00, got.power_01, got.power_10, got.power_11);
        end
        return;
      end
      want = expected_powers.pop_front();
      if (got.power_00 !== want.power_00 || got.power_01 !== want.power_01 ||
          got.power_10 !== want.power_10 || got.power_11 !== want.power_11) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("power mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                   want.power_00, want.power_01, want.power_10, want.power_11,
                   got.power_00, got.power_01, got.power_10, got.power_11);
        end
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int unsigned     cycle_count = 0;
  power_scoreboard powers_sb = new();

  mmp_stream_if #(.T(in_item_t))  req_if ();
  mmp_stream_if #(.T(out_item_t)) rsp_if ();

  modular_matrix_power_2x2 #(
    .EXP_BITS(EXP_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #2 clk = ~clk;

  // Watch both channels; every accepted item is noted before any result is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_if.valid && req_if.ready) powers_sb.note_request(req_if.data);
      if (rsp_if.valid && rsp_if.ready) powers_sb.check_power(rsp_if.data);
    end
  end

  // Result side: stall at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Cycle limit for a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("modular_matrix_power_2x2_tb: errors");
      $finish;
    end
  end

  function automatic in_item_t pack_request(elem_t e00, elem_t e01, elem_t e10,
                                            elem_t e11, logic [EXP_W-1:0] power);
    in_item_t item;
    item.entry_00 = e00;
    item.entry_01 = e01;
    item.entry_10 = e10;
    item.entry_11 = e11;
    item.exponent = power;
    return item;
  endfunction

  // Mostly residues, with some unreduced values and the edges of the range.
  function automatic elem_t random_entry();
    int unsigned pick;
    pick = $urandom_range(15, 0);
    if (pick < 2) return elem_t'($urandom_range(32'h3FFF_FFFF, 32'(MOD_P)));
    if (pick == 2) return MOD_P - 30'd1;
    if (pick == 3) return ELEM_ZERO;
    if (pick == 4) return ELEM_ONE;
    return elem_t'($urandom_range(32'(MOD_P) - 1, 0));
  endfunction

  // Most exponents are short to keep the run fast; a quarter reach up to 63 bits.
  function automatic logic [EXP_W-1:0] random_exponent();
    int unsigned width;
    logic [63:0] raw;
    if ($urandom_range(3, 0) != 0) width = $urandom_range(12, 0);
    else width = $urandom_range(63, 13);
    raw = {$urandom, $urandom};
    if (width == 0) return '0;
    raw = (raw & ((64'd1 << width) - 64'd1)) | (64'd1 << (width - 1));
    return raw[EXP_W-1:0];
  endfunction

  function automatic in_item_t random_request();
    return pack_request(random_entry(), random_entry(), random_entry(), random_entry(),
                        random_exponent());
  endfunction

  // Offer one item, idling first at the current rate, and hold it until accepted.
  task automatic send_request(input in_item_t item);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (powers_sb.expected_powers.size() != 0);
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Corner cases: zero exponent, widest exponent, unreduced and boundary entries.
    send_request(pack_request(ELEM_ZERO, ELEM_ZERO, ELEM_ZERO, ELEM_ZERO, '0));
    send_request(pack_request(MOD_P - 30'd1, MOD_P - 30'd1, MOD_P - 30'd1,
                              MOD_P - 30'd1, 63'd1));
    send_request(pack_request(30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF,
                              30'h3FFF_FFFF, {EXP_W{1'b1}}));
    send_request(pack_request(MOD_P, MOD_P, MOD_P, MOD_P, 63'd5));
    send_request(pack_request(ELEM_ONE, ELEM_ONE, ELEM_ONE, ELEM_ZERO, 63'd10));
    send_request(pack_request(ELEM_ONE, ELEM_ONE, ELEM_ONE, ELEM_ZERO, 63'd1 << 62));
    send_request(pack_request(ELEM_ZERO, ELEM_ZERO, ELEM_ZERO, ELEM_ZERO, 63'd1));
    send_request(pack_request(ELEM_ONE, ELEM_ZERO, ELEM_ZERO, ELEM_ONE, {EXP_W{1'b1}}));
    send_request(pack_request(MOD_P - 30'd1, ELEM_ZERO, ELEM_ZERO, MOD_P - 30'd1, 63'd3));
    send_request(pack_request(30'd2, 30'd3, 30'd5, 30'd7, 63'h2AAA_AAAA_AAAA_AAAA));
    send_request(pack_request(30'd2, 30'd3, 30'd5, 30'd7, 63'h5555_5555_5555_5555));
    send_request(pack_request(MOD_P + 30'd1, 30'h3FFF_FFFF, ELEM_ZERO, MOD_P - 30'd1,
                              63'd2));
    send_request(pack_request(random_entry(), random_entry(), random_entry(),
                              random_entry(), {EXP_W{1'b1}}));
    send_request(pack_request(random_entry(), random_entry(), random_entry(),
                              random_entry(), '0));

    // Random phases: no idling, idle sender, stalling receiver, both lightly.
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 71;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 71;
        end
        default: begin
          send_idle_pct  = 12;
          recv_stall_pct = 12;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_request(random_request());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (powers_sb.error_count == 0 && powers_sb.expected_powers.size() == 0) begin
      $display("modular_matrix_power_2x2_tb: clean");
    end else begin
      $display("modular_matrix_power_2x2_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mmp_pkg.sv
sv/mmp_stream_if.sv
sv/mmp_lane.sv
sv/mmp_ctrl.sv
sv/modular_matrix_power_2x2.sv
test/modular_matrix_power_2x2_tb.sv
